// ----- hdl/tpdi_pkg.sv -----
// tpdi_pkg: shared types and constants for the pcr duplicate inserter
// item structs, csr indexes, state encodings and pcr arithmetic constants
// no dependencies
`default_nettype none

package tpdi_pkg;

   localparam logic [12:0] NULL_PID        = 13'h1FFF;
   // pcr wraps at 2^33 * 300 ticks of 27 MHz
   localparam logic [41:0] PCR_MOD         = 42'd2576980377600;
   // 188 bytes * 8 bits * 27 MHz
   localparam logic [35:0] BITS_TIMES_CLOCK = 36'd40608000000;

   typedef enum logic [1:0] {
      CSR_NEW_PCR_PID   = 2'd0,
      CSR_FIXED_REF_PID = 2'd1,
      CSR_REF_LABEL     = 2'd2,
      CSR_BITRATE       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [12:0] packet_pid;
      logic        carries_pcr;
      logic [41:0] pcr_in;
      logic [31:0] label_bits;
   } req_type;

   typedef struct packed {
      logic        inject_pcr;
      logic [41:0] pcr_out;
      logic        conflict_seen;
      logic [31:0] pcr_total;
      logic [31:0] pcr_missed;
   } rsp_type;

   typedef enum logic [1:0] {
      TOP_IDLE,
      TOP_CALC,
      TOP_EMIT
   } top_state_type;

   typedef enum logic [2:0] {
      SC_IDLE,
      SC_MUL,
      SC_DIV,
      SC_REDUCE,
      SC_SUM,
      SC_DONE
   } sc_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sc_status_type;

endpackage

`default_nettype wire

// ----- hdl/tpdi_scaler.sv -----
// tpdi_scaler: iterative pcr extrapolation, (base + elapsed*C/bitrate) mod pcr range
// shift-add multiply, restoring divide and one shared modular adder
// depends on tpdi_pkg
`default_nettype none

module tpdi_scaler
   import tpdi_pkg::*;
#(
   parameter int INDEX_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [INDEX_WIDTH-1:0] elapsed,
   input  wire logic [31:0]            bitrate,
   input  wire logic [41:0]            base_pcr,
   output sc_status_type               status,
   output logic [41:0]                 pcr_result
);

   localparam int ProdWidth = INDEX_WIDTH + 36;
   localparam int CntWidth  = $clog2(ProdWidth + 1);

   sc_state_type               state_ff, state_in;
   logic [CntWidth-1:0]        cnt_ff, cnt_in;
   logic [INDEX_WIDTH-1:0]     mplier_ff, mplier_in;
   logic [ProdWidth-1:0]       prod_ff, prod_in;
   logic [31:0]                rem_ff, rem_in;
   logic [31:0]                div_ff, div_in;
   logic [41:0]                q_ff, q_in;
   logic [41:0]                base_ff, base_in;

   // shared modular adder
   logic [41:0] ma_a, ma_b, ma_res;
   logic        ma_cin;
   logic [42:0] ma_sum, ma_sub;

   logic [32:0] trial, trial_diff;
   logic        ge;

   always_comb begin
      ma_sum = {1'b0, ma_a} + {1'b0, ma_b} + {42'd0, ma_cin};
      ma_sub = ma_sum - {1'b0, PCR_MOD};
      ma_res = (ma_sum >= {1'b0, PCR_MOD}) ? ma_sub[41:0] : ma_sum[41:0];
   end

   always_comb begin
      trial      = {rem_ff, prod_ff[ProdWidth-1]};
      trial_diff = trial - {1'b0, div_ff};
      ge         = (trial >= {1'b0, div_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff    <= cnt_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      q_ff      <= q_in;
      base_ff   <= base_in;
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      q_in      = q_ff;
      base_in   = base_ff;
      ma_a      = q_ff;
      ma_b      = q_ff;
      ma_cin    = 1'b0;

      case (state_ff)
         SC_MUL: begin
            // msb-first shift-add of elapsed times the packet bit-clock product
            prod_in   = {prod_ff[ProdWidth-2:0], 1'b0}
                        + (mplier_ff[INDEX_WIDTH-1] ? ProdWidth'(BITS_TIMES_CLOCK)
                                                    : '0);
            mplier_in = {mplier_ff[INDEX_WIDTH-2:0], 1'b0};
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               cnt_in   = CntWidth'(ProdWidth - 1);
               state_in = SC_DIV;
            end
         end
         SC_DIV: begin
            // one quotient bit per cycle, quotient kept reduced mod pcr range
            rem_in  = ge ? trial_diff[31:0] : trial[31:0];
            prod_in = {prod_ff[ProdWidth-2:0], 1'b0};
            ma_cin  = ge;
            q_in    = ma_res;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = SC_REDUCE;
            end
         end
         SC_REDUCE: begin
            ma_a     = base_ff;
            ma_b     = '0;
            base_in  = ma_res;
            state_in = SC_SUM;
         end
         SC_SUM: begin
            ma_a     = base_ff;
            ma_b     = q_ff;
            q_in     = ma_res;
            state_in = SC_DONE;
         end
         SC_IDLE, SC_DONE: begin
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase

      if (start) begin
         mplier_in = elapsed;
         div_in    = bitrate;
         base_in   = base_pcr;
         prod_in   = '0;
         rem_in    = '0;
         q_in      = '0;
         cnt_in    = CntWidth'(INDEX_WIDTH - 1);
         // unknown bitrate: no offset
         state_in  = (bitrate == '0) ? SC_REDUCE : SC_MUL;
      end
   end

   always_comb begin
      status.busy = (state_ff != SC_IDLE) && (state_ff != SC_DONE);
      status.done = (state_ff == SC_DONE);
      pcr_result  = q_ff;
   end

endmodule

`default_nettype wire

// ----- hdl/ts_pcr_duplicate_inserter.sv -----
// channel   dir  handshake            payload
// req       in   req_valid/req_ready  req_type: pid, pcr flag, pcr, labels
// rsp       out  rsp_valid/rsp_ready  rsp_type: inject flag, pcr, conflict, counts
// csr       in   csr_valid/csr_ready  csr_index (2 bits), csr_data (32 bits)
//
// an item that does not inject goes through TOP_EMIT into the rsp register once
// that register is free; a new item is accepted only after it has been loaded
// an injecting item first runs the scaler in TOP_CALC, then goes through TOP_EMIT
// (multiply, divide, base reduce, sum; with unknown bitrate only reduce and sum)
// (shift-add multiply over INDEX_WIDTH bits, divide over INDEX_WIDTH+36 bits)
// req_ready is low while an item is in work or while the rsp register is full
// and not being taken; csr is always ready; synchronous reset clears control and
// tracking state, scaler work registers are loaded at start
`default_nettype none

module ts_pcr_duplicate_inserter
   import tpdi_pkg::*;
#(
   parameter int INDEX_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   top_state_type          state_ff, state_in;

   logic [12:0]            new_pid_ff, new_pid_in;
   logic [12:0]            fixed_pid_ff, fixed_pid_in;
   logic [5:0]             ref_label_ff, ref_label_in;
   logic [31:0]            bitrate_ff, bitrate_in;

   logic                   conflict_ff, conflict_in;
   logic                   pending_ff, pending_in;
   logic [12:0]            cur_pid_ff, cur_pid_in;
   logic [41:0]            last_pcr_ff, last_pcr_in;
   logic                   ref_valid_ff, ref_valid_in;
   logic [INDEX_WIDTH-1:0] ref_idx_ff, ref_idx_in;
   logic [INDEX_WIDTH-1:0] pkt_idx_ff, pkt_idx_in;
   logic [31:0]            total_ff, total_in;
   logic [31:0]            missed_ff, missed_in;
   logic                   inject_ff, inject_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   accept, out_free, load_out;
   logic                   sc_start;
   sc_status_type          sc_status;
   logic [41:0]            sc_pcr;
   logic [INDEX_WIDTH-1:0] elapsed;

   logic                   conflict_now, label_on, labelled, switch_ref, fire;
   logic [12:0]            ref_pid_eff;

   tpdi_scaler #(
      .INDEX_WIDTH(INDEX_WIDTH)
   ) u_scaler (
      .clock      (clock),
      .reset      (reset),
      .start      (sc_start),
      .elapsed    (elapsed),
      .bitrate    (bitrate_ff),
      .base_pcr   (last_pcr_ff),
      .status     (sc_status),
      .pcr_result (sc_pcr)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == TOP_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign elapsed   = pkt_idx_ff - ref_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TOP_IDLE;
         new_pid_ff   <= NULL_PID;
         fixed_pid_ff <= NULL_PID;
         ref_label_ff <= 6'd32;
         bitrate_ff   <= '0;
         conflict_ff  <= 1'b0;
         pending_ff   <= 1'b0;
         cur_pid_ff   <= NULL_PID;
         last_pcr_ff  <= '0;
         ref_valid_ff <= 1'b0;
         ref_idx_ff   <= '0;
         pkt_idx_ff   <= '0;
         total_ff     <= '0;
         missed_ff    <= '0;
         inject_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         new_pid_ff   <= new_pid_in;
         fixed_pid_ff <= fixed_pid_in;
         ref_label_ff <= ref_label_in;
         bitrate_ff   <= bitrate_in;
         conflict_ff  <= conflict_in;
         pending_ff   <= pending_in;
         cur_pid_ff   <= cur_pid_in;
         last_pcr_ff  <= last_pcr_in;
         ref_valid_ff <= ref_valid_in;
         ref_idx_ff   <= ref_idx_in;
         pkt_idx_ff   <= pkt_idx_in;
         total_ff     <= total_in;
         missed_ff    <= missed_in;
         inject_ff    <= inject_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // per-item tracking decisions
   always_comb begin
      conflict_now = conflict_ff || (req_data.packet_pid == new_pid_ff);
      fire         = pending_ff && (req_data.packet_pid == NULL_PID) && ref_valid_ff;
      label_on     = !ref_label_ff[5];
      labelled     = label_on && req_data.label_bits[ref_label_ff[4:0]];
      switch_ref   = ((cur_pid_ff == NULL_PID) && !label_on)
                     || (labelled && (req_data.packet_pid != cur_pid_ff)
                         && (req_data.packet_pid != NULL_PID));
      ref_pid_eff  = switch_ref ? req_data.packet_pid : cur_pid_ff;
   end

   always_comb begin
      state_in     = state_ff;
      new_pid_in   = new_pid_ff;
      fixed_pid_in = fixed_pid_ff;
      ref_label_in = ref_label_ff;
      bitrate_in   = bitrate_ff;
      conflict_in  = conflict_ff;
      pending_in   = pending_ff;
      cur_pid_in   = cur_pid_ff;
      last_pcr_in  = last_pcr_ff;
      ref_valid_in = ref_valid_ff;
      ref_idx_in   = ref_idx_ff;
      pkt_idx_in   = pkt_idx_ff;
      total_in     = total_ff;
      missed_in    = missed_ff;
      inject_in    = inject_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      sc_start     = 1'b0;
      load_out     = 1'b0;

      case (state_ff)
         TOP_IDLE: begin
            if (accept) begin
               conflict_in = conflict_now;
               pkt_idx_in  = pkt_idx_ff + 1'b1;
               inject_in   = 1'b0;
               state_in    = TOP_EMIT;
               if (!conflict_now) begin
                  if (fire) begin
                     inject_in  = 1'b1;
                     pending_in = 1'b0;
                     sc_start   = 1'b1;
                     state_in   = TOP_CALC;
                  end else if (req_data.carries_pcr) begin
                     cur_pid_in = ref_pid_eff;
                     if (switch_ref) begin
                        ref_valid_in = 1'b0;
                     end
                     if (req_data.packet_pid == ref_pid_eff) begin
                        total_in = (total_ff != '1) ? total_ff + 1'b1 : total_ff;
                        if (pending_ff && (missed_ff != '1)) begin
                           missed_in = missed_ff + 1'b1;
                        end
                        pending_in   = 1'b1;
                        last_pcr_in  = req_data.pcr_in;
                        ref_valid_in = 1'b1;
                        ref_idx_in   = pkt_idx_ff;
                     end
                  end
               end
            end
         end
         TOP_CALC: begin
            if (sc_status.done) begin
               state_in = TOP_EMIT;
            end
         end
         TOP_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = TOP_IDLE;
            end
         end
         default: begin
            state_in = TOP_IDLE;
         end
      endcase

      if (load_out) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.inject_pcr    = inject_ff;
         rsp_data_in.pcr_out       = inject_ff ? sc_pcr : '0;
         rsp_data_in.conflict_seen = conflict_ff;
         rsp_data_in.pcr_total     = total_ff;
         rsp_data_in.pcr_missed    = missed_ff;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_NEW_PCR_PID: begin
               new_pid_in = csr_data[12:0];
            end
            CSR_FIXED_REF_PID: begin
               fixed_pid_in = csr_data[12:0];
               cur_pid_in   = csr_data[12:0];
            end
            CSR_REF_LABEL: begin
               ref_label_in = csr_data[5:0];
            end
            CSR_BITRATE: begin
               bitrate_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

`ifndef SYNTH
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      sc_start |-> !sc_status.busy)
      else $error("scaler started while busy");

   a_calc_has_scaler: assert property (@(posedge clock) disable iff (reset)
      (state_ff == TOP_CALC) |-> (sc_status.busy || sc_status.done))
      else $error("waiting on idle scaler");

   a_missed_le_total: assert property (@(posedge clock) disable iff (reset)
      missed_ff <= total_ff)
      else $error("missed count above total count");

   a_pcr_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.inject_pcr) |-> (rsp_data_ff.pcr_out < PCR_MOD))
      else $error("injected pcr out of range");
`endif

endmodule

`default_nettype wire
